// File: src/mtss_pkg.sv
package mtss_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned DELTA_W  = 8;
  localparam int unsigned STEP_W   = 7;
  localparam int unsigned REM_W    = 8;
  localparam int unsigned SUM_W    = 9;
  localparam int unsigned DIV_W    = 8;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_MOTION         = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ZOOM_PRESS     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ZOOM_RELEASE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SCROLL_PRESS   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SCROLL_RELEASE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PREC_TOGGLE    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIV = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_DIV  = 1'd1;

  localparam logic [STEP_W-1:0] WHEEL_DIV_RESET = 7'd8;
  localparam logic [STEP_W-1:0] ZOOM_DIV_RESET  = 7'd12;
  localparam logic [STEP_W-1:0] STEP_MIN        = 7'd2;

  typedef enum logic [1:0] {
    SEL_VERT = 2'd0,
    SEL_HORZ = 2'd1,
    SEL_ZOOM = 2'd2
  } sel_t;

  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic commit;
    sel_t sel;
    logic apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_motion;
    logic scroll_active;
    logic zoom_active;
    logic div_last;
  } sts_t;

endpackage

// File: src/mtss_ctrl.sv
module mtss_ctrl import mtss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_VLOAD  = 9'b000000100,
    S_VRUN   = 9'b000001000,
    S_HLOAD  = 9'b000010000,
    S_HRUN   = 9'b000100000,
    S_ZLOAD  = 9'b001000000,
    S_ZRUN   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   apply_pending;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // non-divider items are applied on the way from decode to done
  assign apply_pending = !(sts.is_motion && (sts.scroll_active || sts.zoom_active));

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_VERT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (apply_pending) begin
          cmd.apply = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.scroll_active) begin
          state_nxt = S_VLOAD;
        end else begin
          state_nxt = S_ZLOAD;
        end
      end
      S_VLOAD: begin
        cmd.div_load = 1'b1;
        cmd.sel      = SEL_VERT;
        state_nxt    = S_VRUN;
      end
      S_VRUN: begin
        cmd.div_step = 1'b1;
        cmd.sel      = SEL_VERT;
        if (sts.div_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_HLOAD;
        end
      end
      S_HLOAD: begin
        cmd.div_load = 1'b1;
        cmd.sel      = SEL_HORZ;
        state_nxt    = S_HRUN;
      end
      S_HRUN: begin
        cmd.div_step = 1'b1;
        cmd.sel      = SEL_HORZ;
        if (sts.div_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_ZLOAD: begin
        cmd.div_load = 1'b1;
        cmd.sel      = SEL_ZOOM;
        state_nxt    = S_ZRUN;
      end
      S_ZRUN: begin
        cmd.div_step = 1'b1;
        cmd.sel      = SEL_ZOOM;
        if (sts.div_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/mtss_dp.sv
module mtss_dp import mtss_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  logic [KIND_W-1:0]           in_kind,
  input  logic signed [DELTA_W-1:0]   in_motion_x,
  input  logic signed [DELTA_W-1:0]   in_motion_y,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [STEP_W-1:0]           cfg_data,
  output logic signed [DELTA_W-1:0]   out_pointer_x,
  output logic signed [DELTA_W-1:0]   out_pointer_y,
  output logic signed [DELTA_W-1:0]   out_wheel_vertical,
  output logic signed [DELTA_W-1:0]   out_wheel_horizontal,
  output logic signed [DELTA_W-1:0]   out_zoom_steps,
  output logic                        out_precision_on
);

  logic [STEP_W-1:0] wheel_div_r, zoom_div_r;
  logic              scroll_r, zoom_r, prec_r;
  logic              scroll_nxt, zoom_nxt, prec_nxt;
  logic signed [REM_W-1:0] hrem_r, vrem_r, zrem_r;
  logic signed [REM_W-1:0] hrem_nxt, vrem_nxt, zrem_nxt;

  logic [KIND_W-1:0]         kind_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic signed [DELTA_W-1:0] res_px_r, res_py_r, res_wv_r, res_wh_r, res_zs_r;
  logic signed [DELTA_W-1:0] res_px_nxt, res_py_nxt, res_wv_nxt, res_wh_nxt, res_zs_nxt;

  // serial restoring divider
  logic [DIV_W-1:0]  dvd_r, quo_r;
  logic [STEP_W-1:0] dsr_r, pr_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;

  logic signed [REM_W-1:0]   op_rem;
  logic signed [DELTA_W-1:0] op_delta;
  logic [STEP_W-1:0]         op_step, op_dsr;
  logic signed [SUM_W-1:0]   op_sum, op_abs;
  logic [DIV_W-1:0]          trial, trial_sub;
  logic                      trial_ge;
  logic [STEP_W-1:0]         pr_step;
  logic [DIV_W-1:0]          quo_step;
  logic signed [DELTA_W-1:0] steps_out;
  logic signed [REM_W-1:0]   rem_out;

  assign sts.is_motion     = (kind_r == KIND_MOTION);
  assign sts.scroll_active = scroll_r;
  assign sts.zoom_active   = zoom_r;
  assign sts.div_last      = (cnt_r == {CNT_W{1'b1}});

  always_comb begin
    case (cmd.sel)
      SEL_VERT: begin
        op_rem = vrem_r; op_delta = dy_r; op_step = wheel_div_r;
      end
      SEL_HORZ: begin
        op_rem = hrem_r; op_delta = dx_r; op_step = wheel_div_r;
      end
      SEL_ZOOM: begin
        op_rem = zrem_r; op_delta = dy_r; op_step = zoom_div_r;
      end
      default: begin
        op_rem = vrem_r; op_delta = dy_r; op_step = wheel_div_r;
      end
    endcase
    op_dsr = (op_step < STEP_MIN) ? STEP_MIN : op_step;
    op_sum = SUM_W'(op_rem) + SUM_W'(op_delta);
    op_abs = op_sum[SUM_W-1] ? -op_sum : op_sum;
  end

  assign trial     = {pr_r, dvd_r[DIV_W-1]};
  assign trial_ge  = (trial >= {1'b0, dsr_r});
  assign trial_sub = trial - {1'b0, dsr_r};
  assign pr_step   = trial_ge ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
  assign quo_step  = {quo_r[DIV_W-2:0], trial_ge};

  // emitted count is the negated signed quotient; remainder takes the sum's sign
  assign steps_out = neg_r ? $signed(quo_step) : -$signed(quo_step);
  assign rem_out   = neg_r ? -$signed({1'b0, pr_step}) : $signed({1'b0, pr_step});

  always_comb begin
    scroll_nxt = scroll_r;
    zoom_nxt   = zoom_r;
    prec_nxt   = prec_r;
    hrem_nxt   = hrem_r;
    vrem_nxt   = vrem_r;
    zrem_nxt   = zrem_r;
    res_px_nxt = res_px_r;
    res_py_nxt = res_py_r;
    res_wv_nxt = res_wv_r;
    res_wh_nxt = res_wh_r;
    res_zs_nxt = res_zs_r;
    if (cmd.capture) begin
      res_px_nxt = '0;
      res_py_nxt = '0;
      res_wv_nxt = '0;
      res_wh_nxt = '0;
      res_zs_nxt = '0;
    end
    if (cmd.apply) begin
      case (kind_r)
        KIND_MOTION: begin
          hrem_nxt   = '0;
          vrem_nxt   = '0;
          zrem_nxt   = '0;
          res_px_nxt = dx_r;
          res_py_nxt = dy_r;
        end
        KIND_ZOOM_PRESS: begin
          zoom_nxt = 1'b1;
          hrem_nxt = '0;
          vrem_nxt = '0;
          zrem_nxt = '0;
        end
        KIND_ZOOM_RELEASE: begin
          zoom_nxt = 1'b0;
        end
        KIND_SCROLL_PRESS: begin
          scroll_nxt = 1'b1;
          hrem_nxt   = '0;
          vrem_nxt   = '0;
          zrem_nxt   = '0;
        end
        KIND_SCROLL_RELEASE: begin
          scroll_nxt = 1'b0;
        end
        KIND_PREC_TOGGLE: begin
          prec_nxt = !prec_r;
        end
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      case (cmd.sel)
        SEL_VERT: begin
          vrem_nxt   = rem_out;
          res_wv_nxt = steps_out;
        end
        SEL_HORZ: begin
          hrem_nxt   = rem_out;
          res_wh_nxt = steps_out;
        end
        SEL_ZOOM: begin
          zrem_nxt   = rem_out;
          res_zs_nxt = steps_out;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_div_r <= WHEEL_DIV_RESET;
      zoom_div_r  <= ZOOM_DIV_RESET;
      scroll_r    <= 1'b0;
      zoom_r      <= 1'b0;
      prec_r      <= 1'b0;
      hrem_r      <= '0;
      vrem_r      <= '0;
      zrem_r      <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_WHEEL_DIV) begin
        wheel_div_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_ZOOM_DIV) begin
        zoom_div_r <= cfg_data;
      end
      scroll_r <= scroll_nxt;
      zoom_r   <= zoom_nxt;
      prec_r   <= prec_nxt;
      hrem_r   <= hrem_nxt;
      vrem_r   <= vrem_nxt;
      zrem_r   <= zrem_nxt;
      if (cmd.div_load) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      dx_r   <= in_motion_x;
      dy_r   <= in_motion_y;
    end
    res_px_r <= res_px_nxt;
    res_py_r <= res_py_nxt;
    res_wv_r <= res_wv_nxt;
    res_wh_r <= res_wh_nxt;
    res_zs_r <= res_zs_nxt;
    if (cmd.div_load) begin
      dvd_r <= op_abs[DIV_W-1:0];
      dsr_r <= op_dsr;
      neg_r <= op_sum[SUM_W-1];
      pr_r  <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      pr_r  <= pr_step;
      quo_r <= quo_step;
    end
    if (cmd.out_load) begin
      out_pointer_x        <= res_px_r;
      out_pointer_y        <= res_py_r;
      out_wheel_vertical   <= res_wv_r;
      out_wheel_horizontal <= res_wh_r;
      out_zoom_steps       <= res_zs_r;
      out_precision_on     <= prec_r;
    end
  end

endmodule

// File: src/motion_to_scroll_zoom_steps_unit.sv
// Turns pointer motion and mode key words into pointer, wheel and zoom steps, one
// result word per input word. One word is in flight at a time: a key word or a
// motion word with no mode active goes from decode straight to done; a zoom-mode
// motion word runs the shared 8-step serial divider once, a scroll-mode one twice
// (vertical, then horizontal). The result sits in an output register, so a new
// word is taken while the last result waits on out_stall. Wheel and zoom divisors
// (index 0 and 1) are to be written by the user only while the unit is idle; the
// unit itself does not enforce this. Values below 2 act as 2.
module motion_to_scroll_zoom_steps_unit import mtss_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic signed [DELTA_W-1:0]  in_motion_x,
  input  logic signed [DELTA_W-1:0]  in_motion_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DELTA_W-1:0]  out_pointer_x,
  output logic signed [DELTA_W-1:0]  out_pointer_y,
  output logic signed [DELTA_W-1:0]  out_wheel_vertical,
  output logic signed [DELTA_W-1:0]  out_wheel_horizontal,
  output logic signed [DELTA_W-1:0]  out_zoom_steps,
  output logic                       out_precision_on,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [STEP_W-1:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mtss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtss_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_kind              (in_kind),
    .in_motion_x          (in_motion_x),
    .in_motion_y          (in_motion_y),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_pointer_x        (out_pointer_x),
    .out_pointer_y        (out_pointer_y),
    .out_wheel_vertical   (out_wheel_vertical),
    .out_wheel_horizontal (out_wheel_horizontal),
    .out_zoom_steps       (out_zoom_steps),
    .out_precision_on     (out_precision_on)
  );

endmodule
